// ----- sv/ilp_pkg.sv -----
// Shared types and constants for the integer literal parser.
package ilp_pkg;

  localparam int CHAR_W = 7;
  localparam int MODE_W = 3;
  localparam int POS_W  = 2;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Parse mode codes.
  localparam mode_t M_DEC   = 3'd0;
  localparam mode_t M_ZERO  = 3'd1;
  localparam mode_t M_HEX   = 3'd2;
  localparam mode_t M_OCT   = 3'd3;
  localparam mode_t M_QUOTE = 3'd4;
  localparam mode_t M_ESC   = 3'd5;
  localparam mode_t M_CDONE = 3'd6;

  localparam pos_t POS_START = 2'd0;
  localparam pos_t POS_MAX   = 2'd3;

  // Character codes.
  localparam char_t CH_QUOTE  = 7'h27;
  localparam char_t CH_BSLASH = 7'h5C;
  localparam char_t CH_ZERO   = 7'h30;
  localparam char_t CH_NINE   = 7'h39;
  localparam char_t CH_A_UP   = 7'h41;
  localparam char_t CH_F_UP   = 7'h46;
  localparam char_t CH_A_LO   = 7'h61;
  localparam char_t CH_X_UP   = 7'h58;
  localparam char_t CH_X_LO   = 7'h78;
  localparam char_t CH_O_UP   = 7'h4F;
  localparam char_t CH_O_LO   = 7'h6F;
  localparam char_t CH_N_LO   = 7'h6E;
  localparam char_t CH_R_LO   = 7'h72;
  localparam char_t CH_T_LO   = 7'h74;
  localparam char_t CH_F_LO   = 7'h66;
  localparam char_t CH_V_LO   = 7'h76;

  // Values of the escape sequences.
  localparam char_t ESC_N_VAL = 7'd10;
  localparam char_t ESC_R_VAL = 7'd13;
  localparam char_t ESC_T_VAL = 7'd9;
  localparam char_t ESC_F_VAL = 7'd12;
  localparam char_t ESC_V_VAL = 7'd11;

  // Per-token control state carried between the state registers and the step logic.
  typedef struct packed {
    pos_t  pos;
    mode_t mode;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{pos: POS_START, mode: M_DEC};

endpackage

// ----- sv/integer_literal_parser.sv -----
// Top level of the integer literal parser: input register, step logic and result register.
//
// The parser takes one ASCII character of a literal token per transfer, with in_last set on
// the token's final character, and returns one VALUE_WIDTH-bit two's complement value per
// token. A leading quote gives a character literal (with the escapes n, r, t, f and v), a
// 0x/0X prefix selects hex, 0o/0O selects octal, and anything else reads as decimal; digits
// are not checked and the value wraps modulo 2^VALUE_WIDTH. The block sustains one character
// per clock cycle unless its input is stalled as described below. Each character passes
// through the input register, and the token's value appears on the out_ channel in the
// cycle after its last character leaves that register. The accumulator update is a
// shift-and-add constant multiply feeding back into the state registers, and that loop sets
// the clock period. A result waiting on out_ready stalls the input register only when the
// next character there is itself the last of a token.
module integer_literal_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [6:0]             in_character,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_value
);

  // Input register.
  logic           stg_v_r;
  logic           stg_v_nxt;
  ilp_pkg::char_t stg_char_r;
  logic           stg_last_r;

  // Token state.
  ilp_pkg::ctl_t          ctl_r;
  ilp_pkg::ctl_t          ctl_nxt;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [VALUE_WIDTH-1:0] acc_nxt;

  ilp_pkg::ctl_t          step_ctl;
  logic [VALUE_WIDTH-1:0] step_acc;
  logic                   out_free;
  logic                   advance;
  logic                   in_xfer;

  // The staged character moves on unless it ends a token and the result register is full and not being drained.
  assign advance   = stg_v_r && (!stg_last_r || out_free);
  assign in_ready  = !stg_v_r || advance;
  assign in_xfer   = in_valid && in_ready;
  assign stg_v_nxt = in_xfer || (stg_v_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_char_r <= in_character;
      stg_last_r <= in_last;
    end
  end

  ilp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .ctl_i (ctl_r),
    .acc_i (acc_r),
    .char_i(stg_char_r),
    .ctl_o (step_ctl),
    .acc_o (step_acc)
  );

  // After the last character of a token the state returns to its start values.
  always_comb begin
    ctl_nxt = ctl_r;
    acc_nxt = acc_r;
    if (advance) begin
      ctl_nxt = stg_last_r ? ilp_pkg::CTL_RESET : step_ctl;
      acc_nxt = stg_last_r ? '0 : step_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= ilp_pkg::CTL_RESET;
      acc_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
      acc_r <= acc_nxt;
    end
  end

  ilp_out_reg #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_i   (advance && stg_last_r),
    .value_i  (step_acc),
    .free_o   (out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value)
  );

endmodule

// ----- sv/ilp_step.sv -----
// Combinational next-state logic: folds one character into the token state.
module ilp_step #(
  parameter int VALUE_WIDTH = 32
) (
  input  ilp_pkg::ctl_t          ctl_i,
  input  logic [VALUE_WIDTH-1:0] acc_i,
  input  ilp_pkg::char_t         char_i,
  output ilp_pkg::ctl_t          ctl_o,
  output logic [VALUE_WIDTH-1:0] acc_o
);

  localparam logic [VALUE_WIDTH-1:0] TEN = VALUE_WIDTH'(10);

  logic [VALUE_WIDTH-1:0] ch_w;
  logic [VALUE_WIDTH-1:0] dec_digit;
  logic [VALUE_WIDTH-1:0] hex_digit;
  logic [VALUE_WIDTH-1:0] esc_val;
  logic [VALUE_WIDTH-1:0] acc_x10;

  assign ch_w      = {{(VALUE_WIDTH-ilp_pkg::CHAR_W){1'b0}}, char_i};
  assign dec_digit = ch_w - VALUE_WIDTH'(ilp_pkg::CH_ZERO);
  assign acc_x10   = (acc_i << 3) + (acc_i << 1);

  always_comb begin
    priority if (char_i >= ilp_pkg::CH_ZERO && char_i <= ilp_pkg::CH_NINE) begin
      hex_digit = dec_digit;
    end else if (char_i >= ilp_pkg::CH_A_UP && char_i <= ilp_pkg::CH_F_UP) begin
      hex_digit = ch_w - VALUE_WIDTH'(ilp_pkg::CH_A_UP) + TEN;
    end else begin
      // Anything else goes through the lowercase formula and may wrap.
      hex_digit = ch_w - VALUE_WIDTH'(ilp_pkg::CH_A_LO) + TEN;
    end
  end

  always_comb begin
    unique case (char_i)
      ilp_pkg::CH_N_LO: esc_val = VALUE_WIDTH'(ilp_pkg::ESC_N_VAL);
      ilp_pkg::CH_R_LO: esc_val = VALUE_WIDTH'(ilp_pkg::ESC_R_VAL);
      ilp_pkg::CH_T_LO: esc_val = VALUE_WIDTH'(ilp_pkg::ESC_T_VAL);
      ilp_pkg::CH_F_LO: esc_val = VALUE_WIDTH'(ilp_pkg::ESC_F_VAL);
      ilp_pkg::CH_V_LO: esc_val = VALUE_WIDTH'(ilp_pkg::ESC_V_VAL);
      default:          esc_val = ch_w;
    endcase
  end

  always_comb begin
    ctl_o.pos  = (ctl_i.pos == ilp_pkg::POS_MAX) ? ilp_pkg::POS_MAX : ctl_i.pos + 2'd1;
    ctl_o.mode = ctl_i.mode;
    acc_o      = acc_i;
    if (ctl_i.pos == ilp_pkg::POS_START) begin
      priority if (char_i == ilp_pkg::CH_QUOTE) begin
        ctl_o.mode = ilp_pkg::M_QUOTE;
        acc_o      = '0;
      end else if (char_i == ilp_pkg::CH_ZERO) begin
        ctl_o.mode = ilp_pkg::M_ZERO;
        acc_o      = '0;
      end else begin
        ctl_o.mode = ilp_pkg::M_DEC;
        acc_o      = dec_digit;
      end
    end else begin
      unique case (ctl_i.mode)
        ilp_pkg::M_ZERO: begin
          priority if (char_i == ilp_pkg::CH_X_LO || char_i == ilp_pkg::CH_X_UP) begin
            ctl_o.mode = ilp_pkg::M_HEX;
            acc_o      = '0;
          end else if (char_i == ilp_pkg::CH_O_LO || char_i == ilp_pkg::CH_O_UP) begin
            ctl_o.mode = ilp_pkg::M_OCT;
            acc_o      = '0;
          end else begin
            ctl_o.mode = ilp_pkg::M_DEC;
            acc_o      = acc_x10 + dec_digit;
          end
        end
        ilp_pkg::M_HEX: acc_o = (acc_i << 4) + hex_digit;
        ilp_pkg::M_OCT: acc_o = (acc_i << 3) + dec_digit;
        ilp_pkg::M_QUOTE: begin
          ctl_o.mode = (char_i == ilp_pkg::CH_BSLASH) ? ilp_pkg::M_ESC : ilp_pkg::M_CDONE;
          acc_o      = (char_i == ilp_pkg::CH_BSLASH) ? '0 : ch_w;
        end
        ilp_pkg::M_ESC: begin
          ctl_o.mode = ilp_pkg::M_CDONE;
          acc_o      = esc_val;
        end
        ilp_pkg::M_CDONE: acc_o = acc_i;
        // Decimal, and the unused code that behaves as decimal.
        default: acc_o = acc_x10 + dec_digit;
      endcase
    end
  end

endmodule

// ----- sv/ilp_out_reg.sv -----
// Result register with valid/ready handshake on the output side.
module ilp_out_reg #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   free_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_value
);

  logic                   valid_r;
  logic                   valid_nxt;
  logic [VALUE_WIDTH-1:0] value_r;

  // The register can take a new result if it is empty or being drained now.
  assign free_o    = !valid_r || out_ready;
  assign valid_nxt = load_i || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      value_r <= value_i;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;

endmodule

// ----- sv/ilp_checker.sv -----
// Port-level assertions for the integer literal parser, bound to the top level.
module ilp_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_value
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With room on the output side the input is never held off.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled without back-pressure");

  // A fresh result must trace back to a last-character transfer on the input.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a last character");

endmodule

bind integer_literal_parser ilp_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_ilp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_last  (in_last),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_value(out_value)
);

// ----- tb/sv/integer_literal_parser_check.sv -----
// Watches the integer literal parser's channels, predicts each token's value and compares.
module integer_literal_parser_check
  import ilp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  char_t                  in_character,
  input  logic                   in_last,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [VALUE_WIDTH-1:0] out_value,
  output int                     fail_count,
  output int                     values_due
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam int RADIX_OCT = 8;
  localparam int RADIX_DEC = 10;
  localparam int RADIX_HEX = 16;

  // Parse state of the token in flight, mirrored from the transfers seen on in_.
  pos_t   tok_pos;
  mode_t  tok_mode;
  value_t tok_acc;

  // Values of completed tokens whose result has not been seen yet, oldest first.
  value_t pending_values[$];

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] value mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void clear_token();
    tok_pos  = POS_START;
    tok_mode = M_DEC;
    tok_acc  = '0;
  endfunction

  function automatic value_t hex_value(input char_t ch);
    value_t c;
    c = value_t'(ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) return c - value_t'(CH_ZERO);
    if (ch >= CH_A_UP && ch <= CH_F_UP) return c - value_t'(CH_A_UP) + value_t'(RADIX_DEC);
    // Everything else goes through the lowercase formula and may wrap.
    return c - value_t'(CH_A_LO) + value_t'(RADIX_DEC);
  endfunction

  function automatic value_t escape_value(input char_t ch);
    case (ch)
      CH_N_LO: return value_t'(ESC_N_VAL);
      CH_R_LO: return value_t'(ESC_R_VAL);
      CH_T_LO: return value_t'(ESC_T_VAL);
      CH_F_LO: return value_t'(ESC_F_VAL);
      CH_V_LO: return value_t'(ESC_V_VAL);
      default: return value_t'(ch);
    endcase
  endfunction

  function automatic void take_character(input char_t ch);
    value_t c;
    value_t digit;
    c     = value_t'(ch);
    digit = c - value_t'(CH_ZERO);
    if (tok_pos == POS_START) begin
      if (ch == CH_QUOTE) begin
        tok_mode = M_QUOTE;
        tok_acc  = '0;
      end else if (ch == CH_ZERO) begin
        tok_mode = M_ZERO;
        tok_acc  = '0;
      end else begin
        tok_mode = M_DEC;
        tok_acc  = digit;
      end
    end else begin
      case (tok_mode)
        M_ZERO: begin
          if (ch == CH_X_LO || ch == CH_X_UP) begin
            tok_mode = M_HEX;
            tok_acc  = '0;
          end else if (ch == CH_O_LO || ch == CH_O_UP) begin
            tok_mode = M_OCT;
            tok_acc  = '0;
          end else begin
            tok_mode = M_DEC;
            tok_acc  = value_t'(tok_acc * RADIX_DEC + digit);
          end
        end
        M_HEX: tok_acc = value_t'(tok_acc * RADIX_HEX + hex_value(ch));
        M_OCT: tok_acc = value_t'(tok_acc * RADIX_OCT + digit);
        M_QUOTE: begin
          if (ch == CH_BSLASH) begin
            tok_mode = M_ESC;
            tok_acc  = '0;
          end else begin
            tok_mode = M_CDONE;
            tok_acc  = c;
          end
        end
        M_ESC: begin
          tok_mode = M_CDONE;
          tok_acc  = escape_value(ch);
        end
        M_CDONE: ;
        default: tok_acc = value_t'(tok_acc * RADIX_DEC + digit);
      endcase
    end
    if (tok_pos != POS_MAX) tok_pos = tok_pos + 1'b1;
  endfunction

  always @(posedge clk) begin
    value_t want;
    if (!rst_n) begin
      clear_token();
      pending_values.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_values.size() == 0) begin
          report_mismatch($sformatf("result %0d with no token outstanding",
                                    $signed(out_value)));
        end else begin
          want = pending_values.pop_front();
          if (out_value !== want) begin
            report_mismatch($sformatf("value got %0d (0x%h), want %0d (0x%h)",
                                      $signed(out_value), out_value, $signed(want), want));
          end
        end
      end
      if (in_valid && in_ready) begin
        take_character(in_character);
        if (in_last) begin
          pending_values.push_back(tok_acc);
          clear_token();
        end
      end
    end
    values_due = pending_values.size();
  end

endmodule

// ----- tb/sv/integer_literal_parser_tb.sv -----
// Testbench top for the integer literal parser: clock, reset, stimulus and verdict.
module integer_literal_parser_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ilp_pkg::*;

  localparam int VALUE_WIDTH  = 32;
  localparam int RESET_CYCLES = 12;
  // Margin after every value is back, before the verdict.
  localparam int DRAIN_CYCLES = 8;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES  = 400;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int TOTAL_ITEMS  = 1250;

  localparam char_t CHAR_NUL = 7'h00;
  localparam char_t CHAR_DEL = 7'h7F;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  char_t                  in_character;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_ready;
  logic [VALUE_WIDTH-1:0] out_value;

  int fail_count;
  int values_due;

  // Knobs shared by the sender (main process) and the receiver process, and run counters.
  // idle_rate == 0 means no idling; otherwise a burst starts with odds 1 in idle_rate+1.
  int idle_rate;
  bit hold_request;
  int chars_sent;
  int quiet_cycles;

  // Characters of the token currently being built and sent.
  char_t token_chars[$];

  integer_literal_parser #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value)
  );

  integer_literal_parser_check #(.VALUE_WIDTH(VALUE_WIDTH)) value_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .fail_count   (fail_count),
    .values_due   (values_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver. It decides out_ready once per falling edge, so the block always sees one
  // stable value per cycle. A hold request from the main process overrides any random
  // burst and keeps the result channel blocked for the whole hold.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_rate != 0 &&
                   $urandom_range(0, idle_rate) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog. Any transfer on either channel restarts the count; a long quiet stretch
  // means the block has hung or a result never came.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("** integer_literal_parser: FAILED **");
      $finish;
    end
  end

  // Offers one character and returns at the falling edge after its transfer. It is called
  // at a falling edge. With no gap, in_valid simply stays high into the next character, so
  // valid is never dropped and raised within one time step.
  task automatic send_char(input char_t ch, input logic is_last);
    if (idle_rate != 0 && $urandom_range(0, idle_rate) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_last      <= is_last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_token();
    foreach (token_chars[i]) send_char(token_chars[i], i == token_chars.size() - 1);
  endtask

  task automatic send_text(input string text);
    token_chars.delete();
    for (int i = 0; i < text.len(); i++) token_chars.push_back(char_t'(text[i]));
    send_token();
  endtask

  // Lowers in_valid so nothing is offered twice, then waits for every token's value.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (values_due != 0) @(negedge clk);
  endtask

  // Mostly a well-formed digit of the radix (both letter cases for hex), sometimes any
  // character at all, since the block does not check digits.
  function automatic char_t pick_digit(input int radix);
    int d;
    d = $urandom_range(0, radix - 1);
    if ($urandom_range(0, 15) == 0) return char_t'($urandom);
    if (d < 10) return CH_ZERO + char_t'(d);
    return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + char_t'(d - 10);
  endfunction

  function automatic char_t pick_escape();
    case ($urandom_range(0, 5))
      0:       return CH_N_LO;
      1:       return CH_R_LO;
      2:       return CH_T_LO;
      3:       return CH_F_LO;
      4:       return CH_V_LO;
      default: return char_t'($urandom);
    endcase
  endfunction

  // Builds one random token of at most max_len digits. Most tokens are well-formed decimal,
  // hex, octal or character literals with random content; the rest are pure noise.
  task automatic build_token(input int max_len);
    int len;
    token_chars.delete();
    len = $urandom_range(1, max_len);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        repeat (len) token_chars.push_back(pick_digit(10));
      end
      3, 4: begin
        // A prefix with no digits after it is a legal case, so len - 1 may be zero.
        token_chars.push_back(CH_ZERO);
        token_chars.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
        repeat (len - 1) token_chars.push_back(pick_digit(16));
      end
      5: begin
        token_chars.push_back(CH_ZERO);
        token_chars.push_back($urandom_range(0, 1) ? CH_O_LO : CH_O_UP);
        repeat (len - 1) token_chars.push_back(pick_digit(8));
      end
      6, 7: begin
        token_chars.push_back(CH_QUOTE);
        case ($urandom_range(0, 5))
          0: ;
          1: token_chars.push_back(CH_BSLASH);
          2, 3: begin
            token_chars.push_back(CH_BSLASH);
            token_chars.push_back(pick_escape());
          end
          default: token_chars.push_back(char_t'($urandom));
        endcase
        // Anything after a finished character literal must be ignored.
        repeat ($urandom_range(0, 2)) token_chars.push_back(char_t'($urandom));
      end
      default: begin
        repeat (len) token_chars.push_back(char_t'($urandom));
      end
    endcase
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_character = CHAR_NUL;
    in_last      = 1'b0;
    idle_rate    = 7;
    hold_request = 1'b0;
    chars_sent   = 0;
    quiet_cycles = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed tokens. A lone quote and a quote with only a backslash both give zero.
    send_text("'");
    send_text("'\\");
    send_text("'\\n");
    send_text("'A");
    // Bare prefixes give zero; a single zero is zero and a leading zero falls into decimal.
    send_text("0x");
    send_text("0o");
    send_text("0");
    send_text("07");
    // Mixed-case hex digits after an upper-case prefix, and an upper-case octal prefix.
    send_text("0XfF");
    send_text("0O7");
    // The top character code as a one-character token.
    token_chars.delete();
    token_chars.push_back(CHAR_DEL);
    send_token();
    // Character code zero is an ordinary digit character, not an end of token.
    token_chars.delete();
    token_chars.push_back(CH_ZERO + char_t'(1));
    token_chars.push_back(CHAR_NUL);
    send_token();

    // The sender stops until every value is back. Then the receiver holds off for a long
    // stretch while short tokens keep coming, so results back up and in_ready drops.
    drain_results();
    hold_request = 1'b1;
    repeat (20) begin
      build_token(3);
      send_token();
    end

    // Random tokens under changing idling, including stretches with none at all.
    while (chars_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 31) == 0) begin
        case ($urandom_range(0, 3))
          0:       idle_rate = 0;
          1:       idle_rate = 2;
          2:       idle_rate = 7;
          default: idle_rate = 25;
        endcase
      end
      build_token(12);
      send_token();
    end

    // Final stretch at full rate on both sides.
    idle_rate = 0;
    while (chars_sent < TOTAL_ITEMS) begin
      build_token(12);
      send_token();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("** integer_literal_parser: PASSED **");
    end else begin
      $display("** integer_literal_parser: FAILED **");
    end
    $finish;
  end

endmodule
